@@ rtl/tpk_pkg.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tpk_pkg : shared types and constants
// Widths, opcodes and sequencer states of the tree path engine.
// ---------------------------------------------------------------------------
package tpk_pkg;
   localparam int NODES      = 1024;
   localparam int LEVELS     = 10;
   localparam int VALUE_BITS = 32;
   localparam int NODE_BITS  = $clog2(NODES);
   localparam int LVL_BITS   = (LEVELS > 1) ? $clog2(LEVELS) : 1;
   localparam int TAB_DEPTH  = LEVELS * NODES;
   localparam int TAB_BITS   = $clog2(TAB_DEPTH);
   localparam int LINK_BITS  = NODE_BITS + 1;
   localparam int DEPTH_BITS = 10;
   localparam int LEN_BITS   = 11;
   localparam int CNT_BITS   = 11;

   typedef enum logic [1:0] {
      OP_LOAD  = 2'd0,
      OP_BUILD = 2'd1,
      OP_PATH  = 2'd2,
      OP_KTH   = 2'd3
   } op_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_LOAD,
      ST_LOAD_WR,
      ST_B0_RD,
      ST_B0_PAR,
      ST_B0_WR,
      ST_BL_RD,
      ST_BL_PAR,
      ST_BL_WR,
      ST_Q_DEP,
      ST_Q_DEP2,
      ST_Q_UP_RD,
      ST_Q_UP_WT,
      ST_Q_EQ_RD,
      ST_Q_EQ_WT,
      ST_Q_END_RD,
      ST_Q_END_WT,
      ST_Q_LEN_RD,
      ST_Q_LEN_WT,
      ST_K_RD,
      ST_K_WT,
      ST_OUT
   } state_type;

   // one table port request
   typedef struct packed {
      logic                  wr;
      logic [TAB_BITS-1:0]   addr;
      logic [LINK_BITS-1:0]  link;
      logic [VALUE_BITS-1:0] orv;
   } tab_req_type;

   function automatic logic [TAB_BITS-1:0] tix(input logic [LVL_BITS-1:0] lvl,
                                               input logic [NODE_BITS-1:0] node);
      tix = TAB_BITS'(lvl) * TAB_BITS'(NODES) + TAB_BITS'(node);
   endfunction
endpackage

@@ rtl/tpk_tables.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tpk_tables : jump/or table and node store memories
// Two ports on the jump/or table, two on the node store, registered reads.
// ---------------------------------------------------------------------------
module tpk_tables (
   input  logic                                clock,
   input  tpk_pkg::tab_req_type                ta,
   input  tpk_pkg::tab_req_type                tb,
   output logic [tpk_pkg::LINK_BITS-1:0]       ta_link,
   output logic [tpk_pkg::VALUE_BITS-1:0]      ta_or,
   output logic [tpk_pkg::LINK_BITS-1:0]       tb_link,
   output logic [tpk_pkg::VALUE_BITS-1:0]      tb_or,
   input  logic                                ns_wr,
   input  logic [tpk_pkg::NODE_BITS-1:0]       ns_a_addr,
   input  logic [tpk_pkg::NODE_BITS-1:0]       ns_b_addr,
   input  logic [tpk_pkg::DEPTH_BITS-1:0]      ns_depth,
   input  logic [tpk_pkg::VALUE_BITS-1:0]      ns_value,
   output logic [tpk_pkg::DEPTH_BITS-1:0]      na_depth,
   output logic [tpk_pkg::VALUE_BITS-1:0]      na_value,
   output logic [tpk_pkg::DEPTH_BITS-1:0]      nb_depth,
   output logic [tpk_pkg::VALUE_BITS-1:0]      nb_value
);
   logic [tpk_pkg::LINK_BITS+tpk_pkg::VALUE_BITS-1:0] tab_mem [tpk_pkg::TAB_DEPTH];
   logic [tpk_pkg::DEPTH_BITS+tpk_pkg::VALUE_BITS-1:0] ns_mem [tpk_pkg::NODES];

   // port a of the table only reads; port b writes or reads
   always_ff @(posedge clock) begin
      if (tb.wr) begin
         tab_mem[tb.addr] <= {tb.link, tb.orv};
      end
      {ta_link, ta_or} <= tab_mem[ta.addr];
      {tb_link, tb_or} <= tab_mem[tb.addr];
   end

   always_ff @(posedge clock) begin
      if (ns_wr) begin
         ns_mem[ns_a_addr] <= {ns_depth, ns_value};
      end
      {na_depth, na_value} <= ns_mem[ns_a_addr];
      {nb_depth, nb_value} <= ns_mem[ns_b_addr];
   end
endmodule

@@ rtl/tpk_seq.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tpk_seq : build and query sequencer
// Walks the tables one level a step for builds, path and kth queries.
// ---------------------------------------------------------------------------
module tpk_seq (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  tpk_pkg::op_type                     op,
   input  logic [tpk_pkg::NODE_BITS-1:0]       u_in,
   input  logic [tpk_pkg::NODE_BITS-1:0]       v_in,
   input  logic [tpk_pkg::NODE_BITS-1:0]       par_in,
   input  logic                                has_par_in,
   input  logic [tpk_pkg::DEPTH_BITS-1:0]      dep_in,
   input  logic [tpk_pkg::VALUE_BITS-1:0]      val_in,
   input  logic [tpk_pkg::LEN_BITS-1:0]        x_in,
   input  logic [tpk_pkg::CNT_BITS-1:0]        node_count,
   output logic                                busy,
   output logic                                done,
   output logic [tpk_pkg::NODE_BITS-1:0]       anc,
   output logic [tpk_pkg::VALUE_BITS-1:0]      orv,
   output logic [tpk_pkg::LEN_BITS-1:0]        len,
   output logic [tpk_pkg::NODE_BITS-1:0]       kth,
   output logic                                err
);
   localparam int NB = tpk_pkg::NODE_BITS;
   localparam int LB = tpk_pkg::LVL_BITS;
   localparam int VB = tpk_pkg::VALUE_BITS;
   localparam int DB = tpk_pkg::DEPTH_BITS;
   localparam int KB = tpk_pkg::LINK_BITS;
   localparam int CB = tpk_pkg::CNT_BITS;
   localparam logic [LB-1:0] LTOP = LB'(tpk_pkg::LEVELS - 1);

   tpk_pkg::state_type state_ff, state_in;
   tpk_pkg::op_type op_ff, op_in;
   logic [NB-1:0] a_ff, a_in, b_ff, b_in, u_ff, u_in2, v_ff, v_in2;
   logic [NB-1:0] par_ff, par_in2;
   logic hp_ff, hp_in;
   logic [DB-1:0] dep_ff, dep_in2, du_ff, du_in, dv_ff, dv_in, da_ff, da_in;
   logic [VB-1:0] val_ff, val_in2, o_ff, o_in;
   logic [LB-1:0] lvl_ff, lvl_in;
   logic [CB-1:0] idx_ff, idx_in, cnt_ff, cnt_in;
   logic [tpk_pkg::LEN_BITS-1:0] x_ff, x_in2, len_ff, len_in;
   logic [DB-1:0] diff_ff, diff_in;
   logic [KB-1:0] e_ff, e_in;
   logic [VB-1:0] eo_ff, eo_in;
   logic kerr_ff, kerr_in;
   logic [NB-1:0] kth_ff, kth_in;

   tpk_pkg::tab_req_type ta, tb;
   logic [KB-1:0] ta_link, tb_link;
   logic [VB-1:0] ta_or, tb_or;
   logic ns_wr;
   logic [NB-1:0] ns_a, ns_b;
   logic [DB-1:0] na_depth, nb_depth;
   logic [VB-1:0] na_value, nb_value;

   tpk_tables u_tables (
      .clock(clock), .ta(ta), .tb(tb),
      .ta_link(ta_link), .ta_or(ta_or), .tb_link(tb_link), .tb_or(tb_or),
      .ns_wr(ns_wr), .ns_a_addr(ns_a), .ns_b_addr(ns_b),
      .ns_depth(dep_ff), .ns_value(val_ff),
      .na_depth(na_depth), .na_value(na_value),
      .nb_depth(nb_depth), .nb_value(nb_value)
   );

   function automatic logic [NB-1:0] hop(input logic [KB-1:0] e, input logic [NB-1:0] n);
      hop = e[KB-1] ? e[NB-1:0] : n;
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tpk_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      op_ff <= op_in; a_ff <= a_in; b_ff <= b_in; u_ff <= u_in2; v_ff <= v_in2;
      par_ff <= par_in2; hp_ff <= hp_in; dep_ff <= dep_in2; val_ff <= val_in2;
      du_ff <= du_in; dv_ff <= dv_in; da_ff <= da_in; o_ff <= o_in;
      lvl_ff <= lvl_in; idx_ff <= idx_in; cnt_ff <= cnt_in; x_ff <= x_in2;
      len_ff <= len_in; diff_ff <= diff_in; e_ff <= e_in; eo_ff <= eo_in;
      kerr_ff <= kerr_in; kth_ff <= kth_in;
   end

   always_comb begin
      logic signed [DB+2:0] l;
      logic [DB-1:0] ul, vl, rest;
      state_in = state_ff; op_in = op_ff; a_in = a_ff; b_in = b_ff;
      u_in2 = u_ff; v_in2 = v_ff; par_in2 = par_ff; hp_in = hp_ff;
      dep_in2 = dep_ff; val_in2 = val_ff; du_in = du_ff; dv_in = dv_ff;
      da_in = da_ff; o_in = o_ff; lvl_in = lvl_ff; idx_in = idx_ff;
      cnt_in = cnt_ff; x_in2 = x_ff; len_in = len_ff; diff_in = diff_ff;
      e_in = e_ff; eo_in = eo_ff; kerr_in = kerr_ff; kth_in = kth_ff;
      ta = '0; tb = '0; ns_wr = 1'b0; ns_a = a_ff; ns_b = b_ff;
      l = '0; ul = '0; vl = '0; rest = '0;
      done = 1'b0;
      case (state_ff)
         tpk_pkg::ST_IDLE: begin
            if (start) begin
               op_in = op; u_in2 = u_in; v_in2 = v_in; par_in2 = par_in;
               hp_in = has_par_in; dep_in2 = dep_in; val_in2 = val_in;
               x_in2 = x_in; a_in = u_in; b_in = v_in;
               o_in = '0; len_in = '0; kth_in = '0; kerr_in = 1'b0;
               cnt_in = (node_count > CB'(tpk_pkg::NODES)) ? CB'(tpk_pkg::NODES)
                                                           : node_count;
               idx_in = '0; lvl_in = '0;
               case (op)
                  tpk_pkg::OP_LOAD:  state_in = tpk_pkg::ST_LOAD;
                  tpk_pkg::OP_BUILD: state_in = tpk_pkg::ST_B0_RD;
                  default:           state_in = tpk_pkg::ST_Q_DEP;
               endcase
            end
         end
         // a load keeps the level-0 or entry, so read it before rewriting
         tpk_pkg::ST_LOAD: begin
            ta.addr = tpk_pkg::tix('0, u_ff);
            ns_wr = 1'b1; ns_a = u_ff;
            state_in = tpk_pkg::ST_LOAD_WR;
         end
         tpk_pkg::ST_LOAD_WR: begin
            tb.wr = 1'b1; tb.addr = tpk_pkg::tix('0, u_ff);
            tb.link = hp_ff ? {1'b1, par_ff} : '0; tb.orv = ta_or;
            a_in = '0;
            state_in = tpk_pkg::ST_OUT;
         end
         // level 0: or = value[i] | value[parent], or value[i] alone for a root
         tpk_pkg::ST_B0_RD: begin
            if (idx_ff == cnt_ff) begin
               idx_in = '0; lvl_in = LB'(1);
               state_in = (tpk_pkg::LEVELS > 1) ? tpk_pkg::ST_BL_RD : tpk_pkg::ST_OUT;
               a_in = '0;
            end else begin
               ta.addr = tpk_pkg::tix('0, idx_ff[NB-1:0]);
               ns_a = idx_ff[NB-1:0];
               state_in = tpk_pkg::ST_B0_PAR;
            end
         end
         tpk_pkg::ST_B0_PAR: begin
            e_in = ta_link; eo_in = na_value;
            ns_b = ta_link[NB-1:0];
            state_in = tpk_pkg::ST_B0_WR;
         end
         tpk_pkg::ST_B0_WR: begin
            tb.wr = 1'b1; tb.addr = tpk_pkg::tix('0, idx_ff[NB-1:0]);
            tb.link = e_ff;
            tb.orv = eo_ff | (e_ff[KB-1] ? nb_value : '0);
            idx_in = idx_ff + CB'(1);
            state_in = tpk_pkg::ST_B0_RD;
         end
         tpk_pkg::ST_BL_RD: begin
            if (idx_ff == cnt_ff) begin
               idx_in = '0;
               if (lvl_ff == LTOP) begin
                  a_in = '0; state_in = tpk_pkg::ST_OUT;
               end else begin
                  lvl_in = lvl_ff + LB'(1);
               end
            end else begin
               ta.addr = tpk_pkg::tix(lvl_ff - LB'(1), idx_ff[NB-1:0]);
               state_in = tpk_pkg::ST_BL_PAR;
            end
         end
         tpk_pkg::ST_BL_PAR: begin
            e_in = ta_link; eo_in = ta_or;
            ta.addr = tpk_pkg::tix(lvl_ff - LB'(1), ta_link[NB-1:0]);
            state_in = tpk_pkg::ST_BL_WR;
         end
         tpk_pkg::ST_BL_WR: begin
            tb.wr = 1'b1; tb.addr = tpk_pkg::tix(lvl_ff, idx_ff[NB-1:0]);
            tb.link = e_ff[KB-1] ? ta_link : '0;
            tb.orv = e_ff[KB-1] ? (eo_ff | ta_or) : '0;
            idx_in = idx_ff + CB'(1);
            state_in = tpk_pkg::ST_BL_RD;
         end
         // read depths and values of both endpoints
         tpk_pkg::ST_Q_DEP: begin
            ns_a = u_ff; ns_b = v_ff;
            state_in = tpk_pkg::ST_Q_DEP2;
         end
         tpk_pkg::ST_Q_DEP2: begin
            du_in = na_depth; dv_in = nb_depth;
            o_in = na_value | nb_value;
            if (na_depth < nb_depth) begin
               a_in = v_ff; b_in = u_ff; diff_in = nb_depth - na_depth;
            end else begin
               diff_in = na_depth - nb_depth;
            end
            lvl_in = LTOP;
            state_in = tpk_pkg::ST_Q_UP_RD;
         end
         tpk_pkg::ST_Q_UP_RD: begin
            ta.addr = tpk_pkg::tix(lvl_ff, a_ff);
            state_in = tpk_pkg::ST_Q_UP_WT;
         end
         tpk_pkg::ST_Q_UP_WT: begin
            if (diff_ff[lvl_ff]) begin
               o_in = o_ff | ta_or; a_in = hop(ta_link, a_ff);
            end
            if (lvl_ff == '0) begin
               lvl_in = LTOP;
               state_in = (hop(ta_link, a_ff) == b_ff || (!diff_ff[0] && a_ff == b_ff))
                          ? tpk_pkg::ST_Q_LEN_RD : tpk_pkg::ST_Q_EQ_RD;
               if (!diff_ff[0]) begin
                  state_in = (a_ff == b_ff) ? tpk_pkg::ST_Q_LEN_RD : tpk_pkg::ST_Q_EQ_RD;
               end
            end else begin
               lvl_in = lvl_ff - LB'(1); state_in = tpk_pkg::ST_Q_UP_RD;
            end
         end
         tpk_pkg::ST_Q_EQ_RD: begin
            ta.addr = tpk_pkg::tix(lvl_ff, a_ff);
            tb.addr = tpk_pkg::tix(lvl_ff, b_ff);
            state_in = tpk_pkg::ST_Q_EQ_WT;
         end
         tpk_pkg::ST_Q_EQ_WT: begin
            if (ta_link != tb_link) begin
               o_in = o_ff | ta_or | tb_or;
               a_in = hop(ta_link, a_ff); b_in = hop(tb_link, b_ff);
            end
            if (lvl_ff == '0) begin
               state_in = tpk_pkg::ST_Q_END_RD;
            end else begin
               lvl_in = lvl_ff - LB'(1); state_in = tpk_pkg::ST_Q_EQ_RD;
            end
         end
         tpk_pkg::ST_Q_END_RD: begin
            ta.addr = tpk_pkg::tix('0, a_ff);
            tb.addr = tpk_pkg::tix('0, b_ff);
            state_in = tpk_pkg::ST_Q_END_WT;
         end
         tpk_pkg::ST_Q_END_WT: begin
            o_in = o_ff | ta_or | tb_or;
            a_in = hop(ta_link, a_ff);
            state_in = tpk_pkg::ST_Q_LEN_RD;
         end
         tpk_pkg::ST_Q_LEN_RD: begin
            ns_a = a_ff;
            state_in = tpk_pkg::ST_Q_LEN_WT;
         end
         tpk_pkg::ST_Q_LEN_WT: begin
            da_in = na_depth;
            l = $signed({3'b000, du_ff}) + $signed({3'b000, dv_ff})
                - $signed({2'b00, na_depth, 1'b0});
            len_in = l[DB+2] ? '0 : l[tpk_pkg::LEN_BITS-1:0];
            if (op_ff == tpk_pkg::OP_KTH) begin
               ul = (du_ff > na_depth) ? du_ff - na_depth : '0;
               vl = (dv_ff > na_depth) ? dv_ff - na_depth : '0;
               if (x_ff > (l[DB+2] ? '0 : l[tpk_pkg::LEN_BITS-1:0])) begin
                  kerr_in = 1'b1; state_in = tpk_pkg::ST_OUT;
               end else begin
                  if ({1'b0, ul} >= x_ff) begin
                     b_in = u_ff; diff_in = x_ff[DB-1:0];
                  end else begin
                     rest = x_ff[DB-1:0] - ul;
                     b_in = v_ff; diff_in = (vl >= rest) ? vl - rest : '0;
                  end
                  lvl_in = LTOP; state_in = tpk_pkg::ST_K_RD;
               end
            end else begin
               state_in = tpk_pkg::ST_OUT;
            end
         end
         tpk_pkg::ST_K_RD: begin
            tb.addr = tpk_pkg::tix(lvl_ff, b_ff);
            state_in = tpk_pkg::ST_K_WT;
         end
         tpk_pkg::ST_K_WT: begin
            if (diff_ff[lvl_ff]) begin
               b_in = hop(tb_link, b_ff);
            end
            if (lvl_ff == '0) begin
               kth_in = diff_ff[0] ? hop(tb_link, b_ff) : b_ff;
               state_in = tpk_pkg::ST_OUT;
            end else begin
               lvl_in = lvl_ff - LB'(1); state_in = tpk_pkg::ST_K_RD;
            end
         end
         tpk_pkg::ST_OUT: begin
            done = 1'b1;
            state_in = tpk_pkg::ST_IDLE;
         end
         default: state_in = tpk_pkg::ST_IDLE;
      endcase
   end

   assign busy = (state_ff != tpk_pkg::ST_IDLE);
   assign anc  = (op_ff == tpk_pkg::OP_PATH || op_ff == tpk_pkg::OP_KTH) ? a_ff : '0;
   assign orv  = o_ff;
   assign len  = len_ff;
   assign kth  = kth_ff;
   assign err  = kerr_ff;
endmodule

@@ rtl/tree_path_or_kth_node_engine.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tree_path_or_kth_node_engine : binary lifting tree query engine
// Load, build, path-OR and kth-node queries over a table in memory.
// ---------------------------------------------------------------------------
// Usage: req_ words carry an opcode and operands; every word gives one rsp_
// word. csr_ sets node_count (reset 1024); the user writes it while idle
// only, the block does not enforce it. One word is worked at a time;
// req_stall is high while a word is in flight or its result still waits
// in the output register. Each word steps through the level-indexed
// table memory, whose reads are registered: a path query walks the
// levels once to lift the deeper endpoint and once more to lift both,
// unless one endpoint lies above the other; a kth query walks the levels
// again unless it flags an error; a load reads and rewrites one entry;
// a build visits each level and node through read, parent and write states.
// Reset clears control only; tables are undefined until loaded and built.
// While rsp_stall is high the result word holds and no new word is taken.
// ---------------------------------------------------------------------------
module tree_path_or_kth_node_engine (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [1:0]                          req_opcode,
   input  logic [9:0]                          req_node_u,
   input  logic [9:0]                          req_node_v,
   input  logic [9:0]                          req_parent_node,
   input  logic                                req_has_parent,
   input  logic [9:0]                          req_node_depth,
   input  logic [31:0]                         req_node_value,
   input  logic [10:0]                         req_step_count,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [9:0]                          rsp_ancestor,
   output logic [31:0]                         rsp_path_or,
   output logic [10:0]                         rsp_path_length,
   output logic [9:0]                          rsp_kth_node,
   output logic                                rsp_error,
   input  logic                                csr_write,
   input  logic [10:0]                         csr_node_count
);
   logic [10:0] cnt_ff;
   logic busy, done, start, out_ff;
   logic [9:0] anc, kth;
   logic [31:0] orv;
   logic [10:0] len;
   logic err;

   assign req_stall = busy || out_ff;
   assign start = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 11'd1024;
         out_ff <= 1'b0;
      end else begin
         if (csr_write) cnt_ff <= csr_node_count;
         if (done) out_ff <= 1'b1;
         else if (!rsp_stall) out_ff <= 1'b0;
      end
   end

   tpk_seq u_seq (
      .clock(clock), .reset(reset), .start(start),
      .op(tpk_pkg::op_type'(req_opcode)),
      .u_in(req_node_u), .v_in(req_node_v), .par_in(req_parent_node),
      .has_par_in(req_has_parent), .dep_in(req_node_depth),
      .val_in(req_node_value), .x_in(req_step_count), .node_count(cnt_ff),
      .busy(busy), .done(done), .anc(anc), .orv(orv), .len(len),
      .kth(kth), .err(err)
   );

   assign rsp_valid       = out_ff;
   assign rsp_ancestor    = anc;
   assign rsp_path_or     = orv;
   assign rsp_path_length = len;
   assign rsp_kth_node    = kth;
   assign rsp_error       = err;
endmodule

@@ rtl/tpk_checker.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tpk_checker : port-level checks
// Ordering of words and result fields on the top level ports.
// ---------------------------------------------------------------------------
module tpk_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [9:0]  rsp_kth_node,
   input logic        rsp_error,
   input logic [31:0] rsp_path_or
);
   a_no_take_while_out: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall) else $error("word taken with result pending");
   a_err_kth_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_error |-> rsp_kth_node == 10'd0) else $error("kth with error");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_path_or))
      else $error("result dropped");
   a_one_result: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> !rsp_valid) else $error("result too early");
endmodule

bind tree_path_or_kth_node_engine tpk_checker u_tpk_checker (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
   .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_kth_node(rsp_kth_node),
   .rsp_error(rsp_error), .rsp_path_or(rsp_path_or)
);
